// ----- design/halfband_pyramid_analysis_core_macros.svh -----
// Assertion macros for the pyramid analysis core
`ifndef HALFBAND_PYRAMID_ANALYSIS_CORE_MACROS_SVH
`define HALFBAND_PYRAMID_ANALYSIS_CORE_MACROS_SVH
`ifndef SYNTH
`define HPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define HPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- design/hpa_pkg.sv -----
package hpa_pkg;

   localparam int unsigned MaxTapsDefault = 32;
   localparam int unsigned CoefSlots      = 32;
   localparam int unsigned Lines          = 6;
   localparam int unsigned QueueDepth     = 2;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_COEF   = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] sample;
      logic [4:0]         tap_index;
      logic signed [15:0] coef_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         band;
      logic [2:0]         position;
      logic signed [31:0] value;
      logic               last;
   } rsp_type;

   // Classified command handed from front to back
   typedef struct packed {
      func_type           func;
      logic signed [31:0] sample;
      logic [4:0]         tap_index;
      logic signed [15:0] coef_value;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_WR,
      ST_MAC_RD,
      ST_MAC,
      ST_MAC_LAST,
      ST_PUSH_DONE,
      ST_EMIT_RD,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ----- design/hpa_front.sv -----
module hpa_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hpa_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output hpa_pkg::cmd_type cmd_data
);
   import hpa_pkg::*;

   localparam int unsigned PtrW = $clog2(QueueDepth);

   cmd_type          queue_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]    count_ff, count_in;
   logic             push;
   cmd_type          cmd_new;

   // classify: code 3 passes as FUNC_NONE and is dropped on entry
   always_comb begin
      cmd_new.func       = func_type'(req_data.func);
      cmd_new.sample     = req_data.sample;
      cmd_new.tap_index  = req_data.tap_index;
      cmd_new.coef_value = req_data.coef_value;
   end

   assign req_stall = (count_ff == (PtrW+1)'(QueueDepth));
   assign push      = req_valid && !req_stall && (cmd_new.func != FUNC_NONE);
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? PtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= cmd_new;
   end

endmodule

// ----- design/hpa_back.sv -----
module hpa_back #(
   parameter int unsigned MAX_TAPS = hpa_pkg::MaxTapsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [5:0]       csr_wdata,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  hpa_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hpa_pkg::rsp_type rsp_data
);
   import hpa_pkg::*;

   localparam int unsigned TapW  = $clog2(MAX_TAPS);
   localparam int unsigned CntW  = $clog2(MAX_TAPS + 1);
   localparam int unsigned Depth = Lines * MAX_TAPS;
   localparam int unsigned AddrW = $clog2(Depth);
   // scratch: 0-7 x, 8-11 a1, 12-13 a2, 14 a3, 16-17 r3, 20-23 r2, 24-31 r1
   localparam int unsigned PushCount = 28;

   // storage
   logic signed [31:0] dline_mem [Depth];
   logic signed [15:0] coef_mem [CoefSlots];
   logic signed [31:0] scratch_ff [32];
   logic [TapW-1:0]    ring_ff [Lines];

   state_type           state_ff, state_in;
   logic [5:0]          tap_count_ff;
   logic [2:0]          phase_ff, phase_in;
   logic [4:0]          step_ff, step_in;
   logic [CntW-1:0]     k_ff, k_in;
   logic [TapW-1:0]     rd_ff, rd_in;
   logic [AddrW-1:0]    clr_ff, clr_in;
   logic [3:0]          emit_ff, emit_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic signed [31:0]  dl_q_ff;
   logic signed [15:0]  cf_q_ff;
   logic signed [47:0]  prod_ff;
   logic                load_v_ff;
   logic                prod_v_ff;
   rsp_type             out_ff;
   logic                out_v_ff;

   // per push decoding
   logic [2:0]          line;
   logic [4:0]          step_rel;
   logic [4:0]          src_idx, dst_idx;
   logic                src_zero, keep, dbl;
   logic [CntW-1:0]     n_taps;
   logic [TapW-1:0]     idx_next;
   logic signed [31:0]  push_x;
   logic signed [31:0]  y;
   logic [AddrW-1:0]    base;
   logic signed [31:0]  emit_a, emit_b;
   logic [1:0]          emit_band;
   logic [2:0]          emit_pos;
   logic                out_free;

   assign n_taps = (tap_count_ff > 6'(MAX_TAPS > 63 ? 63 : MAX_TAPS)) ?
                   CntW'(MAX_TAPS) : CntW'(tap_count_ff);

   // schedule of the 28 pushes
   always_comb begin
      line = '0; src_idx = '0; dst_idx = '0; src_zero = 1'b0; keep = 1'b0; dbl = 1'b0;
      step_rel = step_ff - 5'd20;
      if (step_ff < 5'd8) begin
         line = 3'd0; src_idx = step_ff; keep = step_ff[0]; dst_idx = 5'd8 + 5'(step_ff[2:1]);
      end else if (step_ff < 5'd12) begin
         line = 3'd1; src_idx = 5'd8 + 5'(step_ff[1:0]); keep = step_ff[0];
         dst_idx = 5'd12 + 5'(step_ff[1]);
      end else if (step_ff < 5'd14) begin
         line = 3'd2; src_idx = 5'd12 + 5'(step_ff[0]); keep = step_ff[0]; dst_idx = 5'd14;
      end else if (step_ff < 5'd16) begin
         line = 3'd5; src_idx = 5'd14; src_zero = step_ff[0]; keep = 1'b1; dbl = 1'b1;
         dst_idx = 5'd16 + 5'(step_ff[0]);
      end else if (step_ff < 5'd20) begin
         line = 3'd4; src_idx = 5'd12 + 5'(step_ff[1]); src_zero = step_ff[0];
         keep = 1'b1; dbl = 1'b1; dst_idx = 5'd20 + 5'(step_ff[1:0]);
      end else begin
         line = 3'd3; src_idx = 5'd8 + 5'(step_rel[2:1]); src_zero = step_rel[0];
         keep = 1'b1; dbl = 1'b1; dst_idx = 5'd24 + 5'(step_rel[2:0]);
      end
   end

   assign push_x = src_zero ? 32'sd0 : scratch_ff[src_idx];
   assign base   = AddrW'(line) * AddrW'(MAX_TAPS);
   assign idx_next = (CntW'(ring_ff[line]) + 1'b1 < n_taps) ?
                     TapW'(ring_ff[line] + 1'b1) : '0;
   // filter output from the finished accumulator
   always_comb begin
      y = sat32(acc_ff >>> 15);
      if (dbl) y = sat32(64'(y) * 64'sd2);
   end

   // emit sequencing: 15 results
   always_comb begin
      if (emit_ff == 4'd0) begin
         emit_band = 2'd0; emit_pos = 3'd0; emit_a = scratch_ff[14]; emit_b = '0;
      end else if (emit_ff < 4'd3) begin
         emit_band = 2'd1; emit_pos = 3'(emit_ff - 4'd1);
         emit_a = scratch_ff[5'd12 + 5'(emit_pos)]; emit_b = scratch_ff[5'd16 + 5'(emit_pos)];
      end else if (emit_ff < 4'd7) begin
         emit_band = 2'd2; emit_pos = 3'(emit_ff - 4'd3);
         emit_a = scratch_ff[5'd8 + 5'(emit_pos)]; emit_b = scratch_ff[5'd20 + 5'(emit_pos)];
      end else begin
         emit_band = 2'd3; emit_pos = 3'(emit_ff - 4'd7);
         emit_a = scratch_ff[5'(emit_pos)]; emit_b = scratch_ff[5'd24 + 5'(emit_pos)];
      end
   end

   assign out_free = !out_v_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               priority case (cmd_data.func)
                  FUNC_SAMPLE: state_in = (phase_ff == 3'd7) ? ST_PUSH_WR : ST_IDLE;
                  FUNC_CLEAR:  state_in = ST_CLEAR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_PUSH_WR:  state_in = (n_taps == '0) ? ST_PUSH_DONE : ST_MAC_RD;
         ST_MAC_RD:   state_in = (k_ff == n_taps - 1'b1) ? ST_MAC_LAST : ST_MAC;
         ST_MAC:      state_in = (k_ff == n_taps - 1'b1) ? ST_MAC_LAST : ST_MAC;
         ST_MAC_LAST: state_in = (load_v_ff || prod_v_ff) ? ST_MAC_LAST : ST_PUSH_DONE;
         ST_PUSH_DONE:
            state_in = (step_ff == 5'(PushCount - 1)) ? ST_EMIT : ST_PUSH_WR;
         ST_EMIT_RD:  state_in = ST_EMIT;
         ST_EMIT:     state_in = (out_free && emit_ff == 4'd14) ? ST_IDLE : ST_EMIT;
         ST_CLEAR:    state_in = (clr_ff == AddrW'(Depth - 1)) ? ST_IDLE : ST_CLEAR;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      cmd_pop = 1'b0;
      phase_in = phase_ff; step_in = step_ff; k_in = k_ff; rd_in = rd_ff;
      clr_in = clr_ff; emit_in = emit_ff; acc_in = acc_ff;
      if (prod_v_ff) acc_in = acc_ff + 64'(prod_ff);
      unique case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            step_in = '0; emit_in = '0; clr_in = '0;
            if (cmd_valid && cmd_data.func == FUNC_SAMPLE) phase_in = phase_ff + 3'd1;
            if (cmd_valid && cmd_data.func == FUNC_CLEAR) phase_in = '0;
         end
         ST_PUSH_WR: begin
            acc_in = '0; k_in = '0; rd_in = idx_next;
         end
         ST_MAC_RD, ST_MAC: begin
            k_in = k_ff + 1'b1;
            rd_in = (CntW'(rd_ff) + 1'b1 < n_taps) ? TapW'(rd_ff + 1'b1) : '0;
         end
         ST_PUSH_DONE: step_in = step_ff + 5'd1;
         ST_EMIT: if (out_free) emit_in = emit_ff + 4'd1;
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         tap_count_ff <= 6'd1;
         phase_ff <= '0; step_ff <= '0; k_ff <= '0; rd_ff <= '0;
         clr_ff <= '0; emit_ff <= '0; load_v_ff <= 1'b0; prod_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < Lines; i++) ring_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) tap_count_ff <= csr_wdata;
         phase_ff <= phase_in; step_ff <= step_in; k_ff <= k_in; rd_ff <= rd_in;
         clr_ff <= clr_in; emit_ff <= emit_in;
         // operand read, then product: two stages ahead of the accumulator
         load_v_ff <= (state_ff == ST_MAC_RD) || (state_ff == ST_MAC);
         prod_v_ff <= load_v_ff;
         if (state_ff == ST_PUSH_WR) ring_ff[line] <= idx_next;
         if (state_ff == ST_CLEAR)
            for (int i = 0; i < Lines; i++) ring_ff[i] <= '0;
         if (state_ff == ST_EMIT && out_free) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
      end
   end

   // payload registers, MAC pipeline and memories
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      dl_q_ff <= dline_mem[base + AddrW'(rd_ff)];
      cf_q_ff <= coef_mem[k_ff[TapW-1:0] & 5'h1f];
      prod_ff <= dl_q_ff * cf_q_ff;
      if (state_ff == ST_CLEAR) dline_mem[clr_ff] <= '0;
      else if (state_ff == ST_PUSH_WR) dline_mem[base + AddrW'(ring_ff[line])] <= push_x;
      if (state_ff == ST_IDLE && cmd_valid && cmd_data.func == FUNC_COEF &&
          32'(cmd_data.tap_index) < MAX_TAPS)
         coef_mem[cmd_data.tap_index] <= cmd_data.coef_value;
      if (state_ff == ST_IDLE && cmd_valid && cmd_data.func == FUNC_SAMPLE)
         scratch_ff[5'(phase_ff)] <= cmd_data.sample;
      if (state_ff == ST_PUSH_DONE && keep) scratch_ff[dst_idx] <= y;
      if (state_ff == ST_EMIT && out_free) begin
         out_ff.band <= emit_band;
         out_ff.position <= emit_pos;
         out_ff.value <= emit_a - emit_b;
         out_ff.last <= (emit_ff == 4'd14);
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- design/halfband_pyramid_analysis_core.sv -----
// Three-level halfband difference-pyramid analysis.
// Input channel req_*: valid/stall; each transfer carries func, sample,
// tap_index and coef_value. func 0 collects a sample, 1 loads a coefficient,
// 2 clears the delay lines and the group phase. csr_write/csr_wdata set
// tap_count (reset value 1); the user must write it only while the block is idle (not enforced).
// Result channel rsp_*: valid/stall; on every eighth sample 15 results follow:
// coarse value, then details of bands 1, 2 and 3; last marks the fifteenth.
// A two-entry command queue decouples intake from the filter engine.
// Each group runs 28 filter pushes through one shared MAC, each push a
// loop over the taps, then emits 15 results. The MAC loop over the taps
// and the single delay-line memory port bound the throughput.
// After reset the engine sweeps all 6*MAX_TAPS delay-line entries, clearing
// them; a clear command takes the same sweep. When rsp_stall is high the
// result register holds and the engine waits; intake stalls once the queue
// is full.
module halfband_pyramid_analysis_core #(
   parameter int unsigned MAX_TAPS = hpa_pkg::MaxTapsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hpa_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [5:0]       csr_wdata
);
   import hpa_pkg::*;
`include "halfband_pyramid_analysis_core_macros.svh"

   logic    cmd_valid, cmd_pop;
   cmd_type cmd_data;

   hpa_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_pop, .cmd_data
   );

   hpa_back #(.MAX_TAPS(MAX_TAPS)) u_back (
      .clock, .reset, .csr_write, .csr_wdata,
      .cmd_valid, .cmd_pop, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   `HPA_ASSERT_IMPL(a_pop_valid, clock, reset, cmd_pop, cmd_valid, "pop from empty queue")
   `HPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result dropped")
   `HPA_ASSERT_IMPL(a_last_band, clock, reset, rsp_valid && rsp_data.last, rsp_data.band == 2'd3 && rsp_data.position == 3'd7, "last misplaced")

endmodule
